[rtl/csvfe_pkg.sv]
// csvfe_pkg: shared types and constants for the delimited-record field extractor
// used by csvfe_scan, csvfe_outq and csv_field_extractor; no dependencies
`timescale 1ns / 1ps

package csvfe_pkg;

    // buffer size default for the top-level parameter
    localparam int FIELD_BUFFER_SIZE_DEF = 1024;

    // output queue depth, power of two
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

    // result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_FOUND = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_WANTED_FIELD = 2'd0;
    localparam logic [1:0] CFG_DELIMITER    = 2'd1;
    localparam logic [1:0] CFG_OPEN_QUOTE   = 2'd2;
    localparam logic [1:0] CFG_CLOSE_QUOTE  = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // configuration register set
    typedef struct packed {
        logic [7:0] wanted_field;
        logic [7:0] delimiter;
        logic [7:0] open_quote;
        logic [7:0] close_quote;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] position;
        logic [7:0] char_value;
        logic [9:0] length;
        logic       last;
    } result_t;

endpackage

[rtl/csvfe_scan.sv]
// csvfe_scan: record scan state and per-byte decision logic
// depends on csvfe_pkg; emits up to two results per examined byte
`timescale 1ns / 1ps

module csvfe_scan
    import csvfe_pkg::*;
#(
    parameter int FIELD_BUFFER_SIZE = FIELD_BUFFER_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       fire,
    input  logic [7:0] byte_in,
    output logic [1:0] push_cnt,
    output result_t    res0,
    output result_t    res1
);

    localparam int POS_W = $clog2(FIELD_BUFFER_SIZE);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FIELD_BUFFER_SIZE - 1);

    typedef struct packed {
        logic [7:0]       held_byte;
        logic             held_valid;
        logic [7:0]       prev_byte;
        logic             at_first;
        logic             in_quotes;
        logic             after_delim;
        logic [8:0]       field_count;
        logic [POS_W-1:0] write_pos;
        logic             skip_next;
        logic             finished;
    } scan_state_t;

    localparam scan_state_t ST_RESET = '{
        held_byte:   '0,
        held_valid:  1'b0,
        prev_byte:   '0,
        at_first:    1'b1,
        in_quotes:   1'b0,
        after_delim: 1'b0,
        field_count: '0,
        write_pos:   '0,
        skip_next:   1'b0,
        finished:    1'b0
    };

    scan_state_t st_reg;
    scan_state_t st_next;

    // decision logic for one byte, held byte examined with this one as lookahead
    always_comb
    begin
        scan_state_t         st;
        result_t             res [2];
        logic [1:0]          n_res;
        logic [7:0]          c;
        logic [8:0]          wanted;
        logic                first;
        logic                done;
        logic [POS_W+9:0]    wp_ext;

        st       = st_reg;
        res[0]   = '0;
        res[1]   = '0;
        n_res    = 2'd0;
        c        = st_reg.held_byte;
        wanted   = {1'b0, cfg.wanted_field};
        first    = 1'b0;
        done     = 1'b0;
        wp_ext   = '0;

        if (fire)
        begin
            // consume the held byte
            if (st.held_valid && !st.finished)
            begin
                if (st.skip_next)
                begin
                    st.skip_next = 1'b0;
                end
                else
                begin
                    first       = st.at_first;
                    st.at_first = 1'b0;
                    if (!st.in_quotes && st.after_delim && c != CH_SPACE)
                    begin
                        st.after_delim = 1'b0;
                        st.write_pos   = '0;
                    end
                    // doubled quote inside the wanted field
                    if (st.in_quotes && c == CH_DQUOTE && byte_in == CH_DQUOTE
                        && st.field_count == wanted)
                    begin
                        wp_ext = {10'd0, st.write_pos};
                        res[n_res[0]] = '{kind: KIND_CHAR, position: wp_ext[9:0],
                                          char_value: c, length: 10'd0, last: 1'b0};
                        n_res = n_res + 2'd1;
                        st.write_pos = (st.write_pos == POS_LAST) ? '0
                                     : st.write_pos + POS_W'(1);
                        st.skip_next = 1'b1;
                        done = 1'b1;
                    end
                    if (!done && first && c == cfg.open_quote)
                    begin
                        st.in_quotes = 1'b1;
                        done = 1'b1;
                    end
                    if (!done && st.field_count != wanted && st.in_quotes
                        && c == cfg.close_quote)
                    begin
                        st.in_quotes = 1'b0;
                        st.write_pos = '0;
                        done = 1'b1;
                    end
                    if (!done && !st.in_quotes && c == cfg.open_quote)
                    begin
                        st.in_quotes = 1'b1;
                        st.write_pos = '0;
                        done = 1'b1;
                    end
                    if (!done && c == cfg.open_quote && st.prev_byte == cfg.delimiter)
                    begin
                        done = 1'b1;
                    end
                    // close quote right before line end or terminator
                    if (!done && c == cfg.close_quote
                        && (byte_in == CH_LF || byte_in == CH_NUL))
                    begin
                        wp_ext = {10'd0, st.write_pos};
                        res[n_res[0]] = '{
                            kind: (st.write_pos != '0) ? KIND_FOUND : KIND_NONE,
                            position: 10'd0, char_value: 8'd0,
                            length: (st.write_pos != '0) ? wp_ext[9:0] : 10'd0,
                            last: 1'b1};
                        n_res = n_res + 2'd1;
                        st.finished = 1'b1;
                        done = 1'b1;
                    end
                    // newline outside quotes
                    if (!done && !st.in_quotes && c == CH_LF)
                    begin
                        wp_ext = {10'd0, st.write_pos};
                        res[n_res[0]] = '{
                            kind: (st.write_pos != '0) ? KIND_FOUND : KIND_NONE,
                            position: 10'd0, char_value: 8'd0,
                            length: (st.write_pos != '0) ? wp_ext[9:0] : 10'd0,
                            last: 1'b1};
                        n_res = n_res + 2'd1;
                        st.finished = 1'b1;
                        done = 1'b1;
                    end
                    // field separator
                    if (!done && c == cfg.delimiter && !st.in_quotes)
                    begin
                        st.after_delim = 1'b1;
                        st.field_count = st.field_count + 9'd1;
                        if (st.field_count > wanted)
                        begin
                            wp_ext = {10'd0, st.write_pos};
                            res[n_res[0]] = '{kind: KIND_FOUND, position: 10'd0,
                                              char_value: 8'd0, length: wp_ext[9:0],
                                              last: 1'b1};
                            n_res = n_res + 2'd1;
                            st.finished = 1'b1;
                        end
                        else
                        begin
                            st.write_pos = '0;
                        end
                        done = 1'b1;
                    end
                    if (!done && st.field_count > wanted)
                    begin
                        wp_ext = {10'd0, st.write_pos};
                        res[n_res[0]] = '{kind: KIND_FOUND, position: 10'd0,
                                          char_value: 8'd0, length: wp_ext[9:0],
                                          last: 1'b1};
                        n_res = n_res + 2'd1;
                        st.finished = 1'b1;
                        done = 1'b1;
                    end
                    // character of the wanted field
                    if (!done && st.field_count == wanted)
                    begin
                        wp_ext = {10'd0, st.write_pos};
                        if (c == cfg.close_quote)
                        begin
                            res[n_res[0]] = '{kind: KIND_FOUND, position: 10'd0,
                                              char_value: 8'd0, length: wp_ext[9:0],
                                              last: 1'b1};
                            n_res = n_res + 2'd1;
                            st.finished = 1'b1;
                        end
                        else
                        begin
                            res[n_res[0]] = '{kind: KIND_CHAR, position: wp_ext[9:0],
                                              char_value: c, length: 10'd0, last: 1'b0};
                            n_res = n_res + 2'd1;
                            st.write_pos = (st.write_pos == POS_LAST) ? '0
                                         : st.write_pos + POS_W'(1);
                        end
                    end
                end
                st.prev_byte  = c;
                st.held_valid = 1'b0;
            end

            if (byte_in == CH_NUL)
            begin
                // terminator: final result unless already decided, then restart
                if (!st.finished)
                begin
                    wp_ext = {10'd0, st.write_pos};
                    res[n_res[0]] = '{
                        kind: (st.write_pos != '0) ? KIND_FOUND : KIND_NONE,
                        position: 10'd0, char_value: 8'd0,
                        length: (st.write_pos != '0) ? wp_ext[9:0] : 10'd0,
                        last: 1'b1};
                    n_res = n_res + 2'd1;
                end
                st = ST_RESET;
            end
            else if (!st.finished)
            begin
                st.held_byte  = byte_in;
                st.held_valid = 1'b1;
            end
        end

        st_next  = st;
        push_cnt = n_res;
        res0     = res[0];
        res1     = res[1];
    end

    // scan state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // a second result in one step is always the record's final one
    a_second_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt == 2'd2 |-> res1.last && !res0.last)
        else $error("second result of a step is not final");

    // once decided, nonzero bytes produce nothing
    a_quiet_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && st_reg.finished && byte_in != CH_NUL |-> push_cnt == 2'd0)
        else $error("result after end decision");

    // a terminator always leaves a fresh record
    a_zero_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && byte_in == CH_NUL |=> st_reg.at_first && !st_reg.held_valid
                                      && !st_reg.finished)
        else $error("record state not cleared by terminator");

endmodule

[rtl/csvfe_outq.sv]
// csvfe_outq: small result queue, takes up to two results per cycle, gives one
// depends on csvfe_pkg
`timescale 1ns / 1ps

module csvfe_outq
    import csvfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    head
);

    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    result_t               entries_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_next;
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  pop;

    // status
    assign out_valid = (count_reg != '0);
    assign room      = (count_reg <= CNT_W'(OUTQ_DEPTH - 2));
    assign head      = entries_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // pointer and fill updates
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + OUTQ_PTR_W'(pop);
        wr_ptr_next = wr_ptr_reg + OUTQ_PTR_W'(push_cnt);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            entries_reg[wr_ptr_reg + OUTQ_PTR_W'(1)] <= push1;
        end
    end

    // pushes only ever land in free entries
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> count_reg <= CNT_W'(OUTQ_DEPTH) - CNT_W'(push_cnt))
        else $error("result queue overflow");

    // fill level tracks pushes and pops
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt == 2'd0 && !pop |=> $stable(count_reg))
        else $error("queue fill changed without traffic");

endmodule

[rtl/csv_field_extractor.sv]
// csv_field_extractor: top level of the delimited-record field extractor
// depends on csvfe_pkg, csvfe_scan and csvfe_outq
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_ready   data_byte
//  result    out        out_valid / out_ready kind, position, char_value, length, last
//  config    in         cfg_wr_en             cfg_index, cfg_data
//
// one byte accepted per cycle into an input register while the queue has room; it is
// examined against the previously held byte, and its results enter a four-entry queue.
// a byte's character write appears when the following byte arrives (one byte lookahead).
// a terminator can push two results, so a stalled output side throttles the input
// once the queue holds more than two results. reset clears all record state and
// restores the register defaults; no clearing pass.
`timescale 1ns / 1ps

module csv_field_extractor
    import csvfe_pkg::*;
#(
    parameter int FIELD_BUFFER_SIZE = FIELD_BUFFER_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [9:0] position,
    output logic [7:0] char_value,
    output logic [9:0] length,
    output logic       last
);

    cfg_t       cfg_reg;
    logic [7:0] byte_reg;
    logic       byte_valid_reg;
    logic       room;
    logic       fire;
    logic [1:0] push_cnt;
    result_t    res0;
    result_t    res1;
    result_t    head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wanted_field <= 8'd0;
            cfg_reg.delimiter    <= CH_COMMA;
            cfg_reg.open_quote   <= CH_DQUOTE;
            cfg_reg.close_quote  <= CH_DQUOTE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_WANTED_FIELD: cfg_reg.wanted_field <= cfg_data;
                CFG_DELIMITER:    cfg_reg.delimiter    <= cfg_data;
                CFG_OPEN_QUOTE:   cfg_reg.open_quote   <= cfg_data;
                CFG_CLOSE_QUOTE:  cfg_reg.close_quote  <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // input register
    assign fire     = byte_valid_reg && room;
    assign in_ready = !byte_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
    end

    // scan logic
    csvfe_scan #(
        .FIELD_BUFFER_SIZE (FIELD_BUFFER_SIZE)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .fire     (fire),
        .byte_in  (byte_reg),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    // result queue
    csvfe_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // result ports
    assign kind       = head.kind;
    assign position   = head.position;
    assign char_value = head.char_value;
    assign length     = head.length;
    assign last       = head.last;

endmodule
